>>> hdl/pvu_pkg.sv
// Package for the path validator: size defaults, byte codes and the UTF-8 decoder state type.
// Used by pvu_utf8_step and path_utf8_validator. Depends on nothing else.
package pvu_pkg;

  // Default size limits of a path and of one component.
  localparam int unsigned DefMaxPathLength      = 4096;
  localparam int unsigned DefMaxComponentLength = 255;

  // Width of the reported length field.
  localparam int unsigned PathLengthW = 13;

  // Byte codes with a meaning of their own.
  localparam logic [7:0] SlashByte     = 8'h2f;
  localparam logic [7:0] DotByte       = 8'h2e;
  localparam logic [7:0] BackslashByte = 8'h5c;

  // Lead byte ranges.
  localparam logic [7:0] Lead2Lo = 8'hc2;
  localparam logic [7:0] Lead2Hi = 8'hdf;
  localparam logic [7:0] Lead3Lo = 8'he0;
  localparam logic [7:0] Lead3Hi = 8'hef;
  localparam logic [7:0] Lead4Lo = 8'hf0;
  localparam logic [7:0] Lead4Hi = 8'hf4;

  // Code point limits.
  localparam logic [20:0] Min2Byte     = 21'h000080;
  localparam logic [20:0] Min3Byte     = 21'h000800;
  localparam logic [20:0] Min4Byte     = 21'h010000;
  localparam logic [20:0] MaxCodePoint = 21'h10ffff;
  localparam logic [20:0] SurrogateLo  = 21'h00d800;
  localparam logic [20:0] SurrogateHi  = 21'h00dfff;

  // Decoder state kept between bytes of a multibyte sequence.
  typedef struct packed {
    logic [1:0]  tail_rem;
    logic [1:0]  tail_tot;
    logic [20:0] code_point;
  } pvu_utf8_t;

endpackage

>>> hdl/pvu_utf8_step.sv
// One byte step of the UTF-8 decoder: next decoder state and an error flag.
// Depends on pvu_pkg.
module pvu_utf8_step (
  input  pvu_pkg::pvu_utf8_t state_i,
  input  logic [7:0]         byte_i,
  output pvu_pkg::pvu_utf8_t state_o,
  output logic               err_o
);
  import pvu_pkg::*;

  logic [20:0] cp_shift;

  assign cp_shift = {state_i.code_point[14:0], byte_i[5:0]};

  // Continuation handling when a sequence is open, lead decoding otherwise.
  always_comb begin
    state_o = state_i;
    err_o   = 1'b0;
    if (state_i.tail_rem != 2'd0) begin
      if (byte_i[7:6] != 2'b10) begin
        // A bad continuation drops the open sequence.
        err_o            = 1'b1;
        state_o.tail_rem = 2'd0;
      end else begin
        state_o.code_point = cp_shift;
        state_o.tail_rem   = state_i.tail_rem - 2'd1;
        if (state_i.tail_rem == 2'd1) begin
          // Sequence complete: reject overlong forms, surrogates and out-of-range values.
          if ((state_i.tail_tot == 2'd1 && cp_shift < Min2Byte) ||
              (state_i.tail_tot == 2'd2 && cp_shift < Min3Byte) ||
              (state_i.tail_tot == 2'd3 && cp_shift < Min4Byte) ||
              (cp_shift > MaxCodePoint) ||
              (cp_shift >= SurrogateLo && cp_shift <= SurrogateHi)) begin
            err_o = 1'b1;
          end
        end
      end
    end else if (byte_i[7]) begin
      if (byte_i inside {[Lead2Lo:Lead2Hi]}) begin
        state_o.code_point = {16'd0, byte_i[4:0]};
        state_o.tail_tot   = 2'd1;
        state_o.tail_rem   = 2'd1;
      end else if (byte_i inside {[Lead3Lo:Lead3Hi]}) begin
        state_o.code_point = {17'd0, byte_i[3:0]};
        state_o.tail_tot   = 2'd2;
        state_o.tail_rem   = 2'd2;
      end else if (byte_i inside {[Lead4Lo:Lead4Hi]}) begin
        state_o.code_point = {18'd0, byte_i[2:0]};
        state_o.tail_tot   = 2'd3;
        state_o.tail_rem   = 2'd3;
      end else begin
        err_o = 1'b1;
      end
    end
  end

endmodule

>>> hdl/path_utf8_validator.sv
// Top level of the path validator: input beat register, path state update, result register.
// Depends on pvu_pkg and pvu_utf8_step.
// Throughput: one input beat per cycle, byte beats and end beats alike, unless an end beat is held.
// Order: an accepted end beat passes the input register, then the result register, where its
// verdict waits until it is taken; a new beat stalls only behind an end beat that is held
// because the previous verdict has not been taken.
// Reset clears the path state, the mode register (relative mode) and both valid flags.
module path_utf8_validator #(
  parameter int unsigned MAX_PATH_LENGTH      = pvu_pkg::DefMaxPathLength,
  parameter int unsigned MAX_COMPONENT_LENGTH = pvu_pkg::DefMaxComponentLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Mode register write: 1 absolute, 0 relative.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] path_byte
  input  logic        s_axis_tlast,   // end_mark
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] path_ok, [13:1] path_length, [15:14] zero
);
  import pvu_pkg::*;

  localparam int unsigned TotW  = $clog2(MAX_PATH_LENGTH + 2);
  localparam int unsigned CompW = $clog2(MAX_COMPONENT_LENGTH + 2);
  localparam logic [TotW-1:0]  MaxTot  = TotW'(MAX_PATH_LENGTH);
  localparam logic [CompW-1:0] MaxComp = CompW'(MAX_COMPONENT_LENGTH);

  // Mode register.
  logic abs_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q <= 1'b0;
    end else if (cfg_we_i) begin
      abs_q <= cfg_wdata_i;
    end
  end

  // Input beat register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       out_free;
  logic       adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Path state.
  logic             err_q, err_d;
  logic [TotW-1:0]  tot_q, tot_d;
  logic [CompW-1:0] comp_q, comp_d;
  logic             at_first_q, at_first_d;
  logic             fd_q, fd_d;
  logic             sd_q, sd_d;
  pvu_utf8_t        utf_q, utf_d;
  pvu_utf8_t        utf_next;
  logic             utf_err;

  pvu_utf8_step u_utf8_step (
    .state_i (utf_q),
    .byte_i  (in_byte_q),
    .state_o (utf_next),
    .err_o   (utf_err)
  );

  logic is_slash;
  logic is_dot;
  logic close_err;
  logic first_err;
  logic skip_rest;
  logic res_ok;

  assign is_slash  = (in_byte_q == SlashByte);
  assign is_dot    = (in_byte_q == DotByte);
  assign first_err = at_first_q && (abs_q != is_slash);
  assign skip_rest = at_first_q && abs_q && is_slash;

  // Checks made when a component closes.
  assign close_err = (comp_q == '0) || (comp_q > MaxComp) ||
                     (comp_q == CompW'(1) && fd_q) ||
                     (comp_q == CompW'(2) && fd_q && sd_q) ||
                     (!abs_q && fd_q);

  // Per-beat state update and end-of-path verdict.
  always_comb begin
    err_d      = err_q;
    tot_d      = tot_q;
    comp_d     = comp_q;
    at_first_d = at_first_q;
    fd_d       = fd_q;
    sd_d       = sd_q;
    utf_d      = utf_q;
    res_ok     = !(err_q || tot_q == '0 || tot_q > MaxTot ||
                   utf_q.tail_rem != 2'd0 || close_err);
    if (adv) begin
      if (in_last_q) begin
        err_d      = 1'b0;
        tot_d      = '0;
        comp_d     = '0;
        at_first_d = 1'b1;
        fd_d       = 1'b0;
        sd_d       = 1'b0;
        utf_d      = '0;
      end else begin
        if (tot_q <= MaxTot) begin
          tot_d = tot_q + TotW'(1);
        end
        utf_d      = utf_next;
        err_d      = err_q || utf_err || (in_byte_q == BackslashByte) || first_err;
        at_first_d = 1'b0;
        if (!skip_rest) begin
          if (is_slash) begin
            err_d  = err_d || close_err;
            comp_d = '0;
            fd_d   = 1'b0;
            sd_d   = 1'b0;
          end else begin
            if (comp_q == '0) begin
              fd_d = is_dot;
            end else if (comp_q == CompW'(1)) begin
              sd_d = is_dot;
            end
            if (comp_q <= MaxComp) begin
              comp_d = comp_q + CompW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q      <= 1'b0;
      tot_q      <= '0;
      comp_q     <= '0;
      at_first_q <= 1'b1;
      fd_q       <= 1'b0;
      sd_q       <= 1'b0;
      utf_q      <= '0;
    end else begin
      err_q      <= err_d;
      tot_q      <= tot_d;
      comp_q     <= comp_d;
      at_first_q <= at_first_d;
      fd_q       <= fd_d;
      sd_q       <= sd_d;
      utf_q      <= utf_d;
    end
  end

  // Result register.
  logic                   out_ok_q;
  logic [PathLengthW-1:0] out_len_q;
  logic [31:0]            tot_wide;

  assign tot_wide = 32'(tot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_ok_q  <= res_ok;
      out_len_q <= tot_wide[PathLengthW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_len_q, out_ok_q};

  // A new result appears only after an end beat has been processed.
  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && in_last_q))
    else $error("result appeared without an end beat");

  // An end beat held behind a stalled result stays in the input register.
  a_end_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_last_q && out_valid_q && !m_axis_tready) |=> (in_valid_q && in_last_q))
    else $error("end beat lost while result stalled");

  // Processing an end beat returns the path state to its start.
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> (tot_q == '0 && comp_q == '0 && at_first_q && !err_q &&
                            utf_q.tail_rem == 2'd0))
    else $error("path state not cleared after end beat");

  // An accepted path is never empty.
  a_ok_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |-> (out_len_q != '0))
    else $error("accepted path reports zero length");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for path_utf8_validator: paths are streamed in byte beats, verdicts checked.
// Holds its own path and UTF-8 predictor; depends on pvu_pkg and the validator RTL only.
module testbench;
  import pvu_pkg::*;

  localparam int unsigned MaxPath             = DefMaxPathLength;
  localparam int unsigned MaxSeg              = DefMaxComponentLength;
  localparam int unsigned SettleCycles        = 4;
  localparam int unsigned RandomItemsPerPhase = 475;
  localparam int unsigned MaxPrinted          = 100;

  typedef enum logic [1:0] {OP_BYTE, OP_END, OP_MODE, OP_DRAIN} beat_op_e;

  typedef struct packed {
    beat_op_e   op;
    logic [7:0] data;
  } pending_t;

  typedef struct packed {
    logic                   ok;
    logic [PathLengthW-1:0] len;
  } verdict_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] path_byte
  logic        s_axis_tlast  = 1'b0;   // end_mark
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [0] path_ok, [13:1] path_length, [15:14] zero

  path_utf8_validator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Beats waiting to be driven, and verdicts the block still owes us.
  pending_t    pending_q[$];
  verdict_t    verdict_q[$];
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;

  // Predictor state: the mode register and the per-path tracking.
  logic        mode_abs = 1'b0;
  logic        path_broken;
  int unsigned byte_total;
  int unsigned seg_len;
  logic        fresh_path;
  logic        seg_dot0;
  logic        seg_dot1;
  logic [1:0]  tail_left;
  logic [1:0]  tail_len;
  logic [20:0] code_acc;

  function automatic void clear_path_state();
    path_broken = 1'b0;
    byte_total  = 0;
    seg_len     = 0;
    fresh_path  = 1'b1;
    seg_dot0    = 1'b0;
    seg_dot1    = 1'b0;
    tail_left   = 2'd0;
    tail_len    = 2'd0;
    code_acc    = '0;
  endfunction

  // A component ends at a slash or at the end of the path.
  function automatic void close_segment();
    if (seg_len == 0 || seg_len > MaxSeg) path_broken = 1'b1;
    if (seg_len == 1 && seg_dot0) path_broken = 1'b1;
    if (seg_len == 2 && seg_dot0 && seg_dot1) path_broken = 1'b1;
    if (!mode_abs && seg_dot0) path_broken = 1'b1;
    seg_len  = 0;
    seg_dot0 = 1'b0;
    seg_dot1 = 1'b0;
  endfunction

  // UTF-8 decoding of one byte. A bad continuation drops the open sequence without
  // decoding that byte again as a lead.
  function automatic void decode_utf8(input logic [7:0] b);
    if (tail_left != 0) begin
      if (b < 8'h80 || b > 8'hbf) begin
        path_broken = 1'b1;
        tail_left   = 2'd0;
        return;
      end
      code_acc  = {code_acc[14:0], b[5:0]};
      tail_left = tail_left - 2'd1;
      if (tail_left == 0) begin
        if ((tail_len == 2'd1 && code_acc < Min2Byte) ||
            (tail_len == 2'd2 && code_acc < Min3Byte) ||
            (tail_len == 2'd3 && code_acc < Min4Byte) ||
            code_acc > MaxCodePoint ||
            (code_acc >= SurrogateLo && code_acc <= SurrogateHi)) begin
          path_broken = 1'b1;
        end
      end
      return;
    end
    if (b < 8'h80) return;
    if (b >= Lead2Lo && b <= Lead2Hi) begin
      code_acc = {16'd0, b[4:0]};
      tail_len = 2'd1;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      code_acc = {17'd0, b[3:0]};
      tail_len = 2'd2;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      code_acc = {18'd0, b[2:0]};
      tail_len = 2'd3;
    end else begin
      path_broken = 1'b1;
      return;
    end
    tail_left = tail_len;
  endfunction

  // One path byte. The slash rule uses the mode as it stands at the first byte.
  function automatic void take_path_byte(input logic [7:0] b);
    if (byte_total <= MaxPath) byte_total++;
    if (b == BackslashByte) path_broken = 1'b1;
    decode_utf8(b);
    if (fresh_path) begin
      fresh_path = 1'b0;
      if (mode_abs) begin
        if (b == SlashByte) return;
        path_broken = 1'b1;
      end else if (b == SlashByte) begin
        path_broken = 1'b1;
      end
    end
    if (b == SlashByte) begin
      close_segment();
    end else begin
      if (seg_len == 0) seg_dot0 = (b == DotByte);
      else if (seg_len == 1) seg_dot1 = (b == DotByte);
      if (seg_len <= MaxSeg) seg_len++;
    end
  endfunction

  // The end beat yields the verdict and starts a fresh path.
  function automatic void finish_path();
    verdict_t v;
    if (byte_total == 0 || byte_total > MaxPath) path_broken = 1'b1;
    if (tail_left != 0) path_broken = 1'b1;
    close_segment();
    v.ok  = !path_broken;
    v.len = PathLengthW'(byte_total);
    verdict_q.push_back(v);
    clear_path_state();
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got_v,
                               input int unsigned exp_v);
    if (mismatches < MaxPrinted) begin
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got_v, exp_v);
    end
    mismatches++;
  endtask

  // Driver: launches pending beats, writes the mode register once the block is quiet,
  // and feeds every accepted beat to the predictor.
  always @(posedge clk_i) begin : drive_proc
    pending_t   head;
    logic       nxt_valid;
    logic       nxt_last;
    logic       nxt_we;
    logic       nxt_wdata;
    logic [7:0] nxt_data;
    if (!rst_ni) begin
      mode_abs = 1'b0;
      clear_path_state();
      quiet_cycles = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_last  = s_axis_tlast;
      nxt_data  = s_axis_tdata;
      nxt_we    = 1'b0;
      nxt_wdata = cfg_wdata_i;
      if (cfg_we_i) mode_abs = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tlast) finish_path();
        else take_path_byte(s_axis_tdata);
        nxt_valid = 1'b0;
      end
      if (!s_axis_tvalid && !cfg_we_i && verdict_q.size() == 0) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nxt_valid && !cfg_we_i && pending_q.size() != 0) begin
        head = pending_q[0];
        case (head.op)
          OP_BYTE, OP_END: begin
            if ($urandom_range(0, 99) >= idle_pct) begin
              void'(pending_q.pop_front());
              nxt_valid = 1'b1;
              nxt_data  = head.data;
              nxt_last  = (head.op == OP_END);
            end
          end
          default: begin
            // Mode writes and drain points wait until nothing is in flight.
            if (quiet_cycles >= SettleCycles) begin
              void'(pending_q.pop_front());
              if (head.op == OP_MODE) begin
                nxt_we    = 1'b1;
                nxt_wdata = head.data[0];
              end
            end
          end
        endcase
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tlast  <= nxt_last;
      s_axis_tdata  <= nxt_data;
      cfg_we_i      <= nxt_we;
      cfg_wdata_i   <= nxt_wdata;
    end
  end

  // Monitor: checks each verdict beat against the oldest prediction and stalls at random.
  always @(posedge clk_i) begin : check_proc
    verdict_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          note_mismatch("verdict with no path pending", 32'(m_axis_tdata), 0);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want.ok) begin
            note_mismatch("path_ok", 32'(m_axis_tdata[0]), 32'(want.ok));
          end
          if (m_axis_tdata[13:1] !== want.len) begin
            note_mismatch("path_length", 32'(m_axis_tdata[13:1]), 32'(want.len));
          end
          if (m_axis_tdata[15:14] !== 2'b00) begin
            note_mismatch("pad bits", 32'(m_axis_tdata[15:14]), 0);
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stimulus building.
  logic        gen_mode      = 1'b0;
  int unsigned queued_items  = 0;

  task automatic push_beat(input beat_op_e op, input logic [7:0] d);
    pending_t p;
    p.op   = op;
    p.data = d;
    pending_q.push_back(p);
    if (op == OP_BYTE || op == OP_END) queued_items++;
  endtask

  task automatic put(input logic [7:0] b);
    push_beat(OP_BYTE, b);
  endtask

  task automatic put_end();
    push_beat(OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic set_mode(input logic m);
    push_beat(OP_MODE, {7'd0, m});
    gen_mode = m;
  endtask

  // A code point that is well formed for an n-byte sequence.
  function automatic logic [20:0] pick_code(input int unsigned n);
    if (n == 2) return 21'($urandom_range(Min2Byte, Min3Byte - 1));
    if (n == 3) begin
      if ($urandom_range(0, 1) != 0) return 21'($urandom_range(Min3Byte, SurrogateLo - 1));
      return 21'($urandom_range(SurrogateHi + 1, Min4Byte - 1));
    end
    return 21'($urandom_range(Min4Byte, MaxCodePoint));
  endfunction

  // Encodes a code point in n bytes, whatever its size, and queues the first keep bytes.
  task automatic put_seq(input logic [20:0] cp, input int unsigned n,
                         input int unsigned keep, inout int unsigned count);
    logic [7:0] enc [0:3];
    case (n)
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int unsigned i = 0; i < keep; i++) put(enc[i]);
    count += keep;
  endtask

  // One character inside a component: mostly clean text, some flawed UTF-8 and noise.
  task automatic push_char(inout int unsigned count);
    int unsigned r;
    int unsigned n;
    logic [7:0]  b;
    logic [20:0] lim;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      put(8'h61 + 8'($urandom_range(0, 25)));
      count++;
    end else if (r < 60) begin
      b = 8'($urandom_range(0, 127));
      if (b == SlashByte) b = DotByte;
      put(b);
      count++;
    end else if (r < 85) begin
      n = $urandom_range(2, 4);
      put_seq(pick_code(n), n, n, count);
    end else if (r < 95) begin
      case ($urandom_range(0, 5))
        0: begin
          // Overlong form.
          n   = $urandom_range(2, 4);
          lim = (n == 2) ? Min2Byte : (n == 3) ? Min3Byte : Min4Byte;
          put_seq(21'($urandom_range(0, lim - 1)), n, n, count);
        end
        1: put_seq(21'($urandom_range(SurrogateLo, SurrogateHi)), 3, 3, count);
        2: put_seq(21'($urandom_range(MaxCodePoint + 1, 21'h1fffff)), 4, 4, count);
        3: begin
          // Truncated sequence; a following byte that is no continuation acts as a bad one.
          n = $urandom_range(2, 4);
          put_seq(pick_code(n), n, $urandom_range(1, n - 1), count);
        end
        4: begin
          put(8'($urandom_range(8'h80, 8'hbf)));
          count++;
        end
        default: begin
          if ($urandom_range(0, 1) != 0) put(8'($urandom_range(8'hc0, 8'hc1)));
          else put(8'($urandom_range(8'hf5, 8'hff)));
          count++;
        end
      endcase
    end else begin
      b = 8'($urandom_range(0, 255));
      if (b == SlashByte) b = BackslashByte;
      put(b);
      count++;
    end
  endtask

  task automatic push_segment();
    int unsigned r;
    int unsigned target;
    int unsigned count;
    r     = $urandom_range(0, 99);
    count = 0;
    if (r < 5) begin
      put(DotByte);
    end else if (r < 10) begin
      put(DotByte);
      put(DotByte);
    end else if (r < 14) begin
      // Empty component.
    end else if (r < 17) begin
      // Clean text around the component length limit.
      target = $urandom_range(MaxSeg - 4, MaxSeg + 3);
      repeat (target) put(8'h61 + 8'($urandom_range(0, 25)));
    end else begin
      target = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) begin
        put(DotByte);
        count = 1;
      end
      while (count < target) push_char(count);
    end
  endtask

  // A random path: mostly well shaped for the current mode, some noise paths.
  task automatic push_path();
    int unsigned nseg;
    if ($urandom_range(0, 29) == 0) set_mode(1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 3) begin
      repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
    end else begin
      if (gen_mode ^ ($urandom_range(0, 9) == 0)) put(SlashByte);
      nseg = $urandom_range(1, 4);
      for (int unsigned i = 0; i < nseg; i++) begin
        if (i != 0) put(SlashByte);
        if (i == 1 && $urandom_range(0, 49) == 0) set_mode(!gen_mode);
        push_segment();
      end
      if ($urandom_range(0, 19) == 0) put(SlashByte);
    end
    if ($urandom_range(0, 99) == 0) push_beat(OP_DRAIN, 8'h00);
    put_end();
  endtask

  // Reset, then four idling phases: none, sender idle, receiver stalling, both.
  initial begin : stim_proc
    int unsigned target;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int unsigned ph = 0; ph < 4; ph++) begin
      while (pending_q.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
      idle_pct  = (ph == 1) ? 61 : (ph == 3) ? 12 : 0;
      stall_pct = (ph == 2) ? 61 : (ph == 3) ? 12 : 0;
      set_mode(ph[0]);
      if (ph == 0) begin
        // Relative mode: empty path, zero byte, leading slash, bad continuation,
        // backslash with an invalid lead and a stray continuation.
        put_end();
        put(8'h00); put_end();
        put(SlashByte); put(8'h61); put_end();
        put(8'hc3); put(8'h41); put_end();
        put(BackslashByte); put(8'hff); put(8'h80); put_end();
        // Mode switched to absolute in the middle of a path.
        put(8'h61); set_mode(1'b1); put(SlashByte); put(8'h62); put_end();
        // Absolute mode: dot and dot-dot components, a valid four-byte character.
        put(SlashByte); put(DotByte); put_end();
        put(SlashByte); put(DotByte); put(DotByte); put_end();
        put(SlashByte); put(8'hf0); put(8'h9f); put(8'h98); put(8'h80); put_end();
        push_beat(OP_DRAIN, 8'h00);
      end
      target = queued_items + RandomItemsPerPhase;
      while (queued_items < target) push_path();
    end
    while (pending_q.size() != 0 || verdict_q.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles * 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog_proc
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
hdl/pvu_pkg.sv
hdl/pvu_utf8_step.sv
hdl/path_utf8_validator.sv
tb/sv/testbench.sv
